>>> rtl/core/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types and constants for the per-line KMP pattern counter.
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

    // Request codes on req_type
    typedef enum logic [2:0] {
        REQ_START  = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_TEXT   = 3'd2,
        REQ_EOL    = 3'd3,
        REQ_EOT    = 3'd4
    } req_type_t;

    // Report kinds on report_kind
    localparam logic RPT_LINE  = 1'b0;
    localparam logic RPT_TOTAL = 1'b1;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned LINE_W  = 16;
    localparam int unsigned COUNT_W = 24;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [LINE_W-1:0]  line_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Matcher sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_FOLLOW
    } kpc_state_t;

endpackage

`default_nettype wire

>>> rtl/core/kmp_pattern_count_per_line.sv
// ----------------------------------------------------------------------------
// kmp_pattern_count_per_line
// Counts non-overlapping KMP matches of a loaded pattern, per line and total.
//
//   channel | dir | handshake                  | payload
//   --------+-----+----------------------------+----------------------------------
//   request | in  | req_valid / req_ready      | req_type, char_value
//   report  | out | report_valid / report_ready| report_kind, line_number,
//           |     |                            | match_count
//
// Start-pattern, end-of-line, end-of-text and ignored requests finish on accept,
// as do a first pattern byte, a byte past a full pattern and text with no pattern.
// Other append and text requests go to ST_CMP, then to ST_FOLLOW and back to ST_CMP
// once per border fallback step: each step is one read of the pattern memory and
// one of the border memory. Pattern and border memories are not cleared at reset;
// only entries below the pattern length are ever used. A request is taken only
// in the idle state and while the report register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module kmp_pattern_count_per_line #(
    parameter int PAT_MAX = 128
) (
    input  wire                   clk,
    input  wire                   rst_n,

    input  wire                   req_valid,
    output logic                  req_ready,
    input  wire  [2:0]            req_type,
    input  kpc_pkg::char_t        char_value,

    output logic                  report_valid,
    input  wire                   report_ready,
    output logic                  report_kind,
    output kpc_pkg::line_t        line_number,
    output kpc_pkg::count_t       match_count
);

    import kpc_pkg::*;

    localparam int IW = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int LW = $clog2(PAT_MAX + 1);

    typedef logic [IW-1:0] idx_t;
    typedef logic [LW-1:0] len_t;

    // Memories
    char_t pat_mem [PAT_MAX];
    idx_t  bor_mem [PAT_MAX];

    char_t pat_rd_reg;
    idx_t  bor_rd_reg;

    idx_t  pat_raddr;
    idx_t  bor_raddr;
    logic  pat_we;
    idx_t  pat_waddr;
    char_t pat_wdata;
    logic  bor_we;
    idx_t  bor_waddr;
    idx_t  bor_wdata;

    // Control state
    kpc_state_t state_reg, state_next;
    len_t   length_reg, length_next;
    idx_t   build_reg, build_next;
    idx_t   match_reg, match_next;
    count_t line_cnt_reg, line_cnt_next;
    count_t total_cnt_reg, total_cnt_next;
    line_t  cur_line_reg, cur_line_next;

    // Work context of the current append or text request
    idx_t   k_reg, k_next;
    char_t  char_reg, char_next;
    logic   build_mode_reg, build_mode_next;

    // Report register
    logic   out_valid_reg, out_valid_next;
    logic   out_kind_reg, out_kind_next;
    line_t  out_line_reg, out_line_next;
    count_t out_count_reg, out_count_next;

    logic   accept;
    logic   finish;
    len_t   k_new;

    assign req_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || report_ready);
    assign accept       = req_valid && req_ready;
    assign report_valid = out_valid_reg;
    assign report_kind  = out_kind_reg;
    assign line_number  = out_line_reg;
    assign match_count  = out_count_reg;

    // Memory ports: registered read every cycle, single write
    always_ff @(posedge clk)
    begin
        pat_rd_reg <= pat_mem[pat_raddr];
        bor_rd_reg <= bor_mem[bor_raddr];
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= pat_wdata;
        end
        if (bor_we)
        begin
            bor_mem[bor_waddr] <= bor_wdata;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            length_reg     <= '0;
            build_reg      <= '0;
            match_reg      <= '0;
            line_cnt_reg   <= '0;
            total_cnt_reg  <= '0;
            cur_line_reg   <= line_t'(1);
            out_valid_reg  <= 1'b0;
            build_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            length_reg     <= length_next;
            build_reg      <= build_next;
            match_reg      <= match_next;
            line_cnt_reg   <= line_cnt_next;
            total_cnt_reg  <= total_cnt_next;
            cur_line_reg   <= cur_line_next;
            out_valid_reg  <= out_valid_next;
            build_mode_reg <= build_mode_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        char_reg      <= char_next;
        out_kind_reg  <= out_kind_next;
        out_line_reg  <= out_line_next;
        out_count_reg <= out_count_next;
    end

    // Next state and memory control
    always_comb
    begin
        state_next      = state_reg;
        length_next     = length_reg;
        build_next      = build_reg;
        match_next      = match_reg;
        line_cnt_next   = line_cnt_reg;
        total_cnt_next  = total_cnt_reg;
        cur_line_next   = cur_line_reg;
        k_next          = k_reg;
        char_next       = char_reg;
        build_mode_next = build_mode_reg;
        out_valid_next  = out_valid_reg && !report_ready;
        out_kind_next   = out_kind_reg;
        out_line_next   = out_line_reg;
        out_count_next  = out_count_reg;

        pat_raddr = k_reg;
        bor_raddr = k_reg - idx_t'(1);
        pat_we    = 1'b0;
        pat_waddr = length_reg[IW-1:0];
        pat_wdata = char_value;
        bor_we    = 1'b0;
        bor_waddr = length_reg[IW-1:0];
        bor_wdata = '0;
        finish    = 1'b0;
        k_new     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_START:
                        begin
                            // New search: first byte has an empty border
                            pat_we         = 1'b1;
                            pat_waddr      = '0;
                            bor_we         = 1'b1;
                            bor_waddr      = '0;
                            bor_wdata      = '0;
                            length_next    = len_t'(1);
                            build_next     = '0;
                            match_next     = '0;
                            line_cnt_next  = '0;
                            total_cnt_next = '0;
                            cur_line_next  = line_t'(1);
                        end
                        REQ_APPEND:
                        begin
                            if (length_reg < len_t'(PAT_MAX))
                            begin
                                pat_we = 1'b1;
                                if (length_reg == '0)
                                begin
                                    bor_we      = 1'b1;
                                    bor_wdata   = '0;
                                    length_next = len_t'(1);
                                    build_next  = '0;
                                end
                                else
                                begin
                                    // build_reg < length, so no clash with the write
                                    pat_raddr       = build_reg;
                                    k_next          = build_reg;
                                    char_next       = char_value;
                                    build_mode_next = 1'b1;
                                    state_next      = ST_CMP;
                                end
                            end
                        end
                        REQ_TEXT:
                        begin
                            if (length_reg != '0)
                            begin
                                pat_raddr       = match_reg;
                                k_next          = match_reg;
                                char_next       = char_value;
                                build_mode_next = 1'b0;
                                state_next      = ST_CMP;
                            end
                        end
                        REQ_EOL:
                        begin
                            if (line_cnt_reg != '0)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = RPT_LINE;
                                out_line_next  = cur_line_reg;
                                out_count_next = line_cnt_reg;
                            end
                            line_cnt_next = '0;
                            match_next    = '0;
                            cur_line_next = cur_line_reg + line_t'(1);
                        end
                        REQ_EOT:
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = RPT_TOTAL;
                            out_line_next  = '0;
                            out_count_next = total_cnt_reg;
                            match_next     = '0;
                            line_cnt_next  = '0;
                            total_cnt_next = '0;
                            cur_line_next  = line_t'(1);
                        end
                        default:
                        begin
                            // unknown request: ignored
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (pat_rd_reg == char_reg)
                begin
                    finish = 1'b1;
                    k_new  = len_t'(k_reg) + len_t'(1);
                end
                else if (k_reg != '0)
                begin
                    // fall back: fetch border of k-1
                    bor_raddr  = k_reg - idx_t'(1);
                    state_next = ST_FOLLOW;
                end
                else
                begin
                    finish = 1'b1;
                    k_new  = '0;
                end
            end
            ST_FOLLOW:
            begin
                k_next     = bor_rd_reg;
                pat_raddr  = bor_rd_reg;
                state_next = ST_CMP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Wrap up an append or text step
        if (finish)
        begin
            state_next = ST_IDLE;
            if (build_mode_reg)
            begin
                bor_we      = 1'b1;
                bor_wdata   = k_new[IW-1:0];
                build_next  = k_new[IW-1:0];
                length_next = length_reg + len_t'(1);
            end
            else if (k_new >= length_reg)
            begin
                if (line_cnt_reg != COUNT_MAX)
                begin
                    line_cnt_next = line_cnt_reg + count_t'(1);
                end
                if (total_cnt_reg != COUNT_MAX)
                begin
                    total_cnt_next = total_cnt_reg + count_t'(1);
                end
                match_next = '0;
            end
            else
            begin
                match_next = k_new[IW-1:0];
            end
        end
    end

    // Checks
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (len_t'(k_reg) < length_reg))
        else $error("match index not below pattern length during walk");

    a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (match_reg == '0) || (len_t'(match_reg) < length_reg))
        else $error("match position beyond pattern length");

    a_border_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (build_reg == '0) || (len_t'(build_reg) < length_reg))
        else $error("build border beyond pattern length");

    a_total_ge_line: assert property (@(posedge clk) disable iff (!rst_n)
        total_cnt_reg >= line_cnt_reg)
        else $error("line count exceeds total count");

endmodule

`default_nettype wire
